// ----- rtl/rbb_pkg.sv -----
// shared types, constants and helpers for the byte ring buffer
package rbb_pkg;

  localparam int unsigned CNT_W     = 13;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned OFF_W     = 12;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned DEPTH_DEF = 4096;
  localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT     = 2'd0,
    ACT_GET     = 2'd1,
    ACT_PEEK    = 2'd2,
    ACT_DISCARD = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NO_ROOM = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] value,
                                               input int unsigned depth);
    logic [CNT_W-1:0] r;
    if (value == '0) begin
      r = CNT_W'(1);
    end else if (32'(value) > depth) begin
      r = CNT_W'(depth);
    end else begin
      r = value;
    end
    return r;
  endfunction

endpackage

// ----- rtl/rbb_store.sv -----
// byte store: single-port synchronous ram with registered read data
module rbb_store #(
  parameter int unsigned DEPTH = rbb_pkg::DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              addr,
  input  logic [rbb_pkg::DATA_W-1:0] wdata,
  output logic [rbb_pkg::DATA_W-1:0] rdata
);

  logic [rbb_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/rbb_ctrl.sv -----
// ring pointers, fill count, write admission and result registers
module rbb_ctrl #(
  parameter int unsigned DEPTH = rbb_pkg::DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [rbb_pkg::ACT_W-1:0]  action,
  input  logic [rbb_pkg::DATA_W-1:0] data,
  input  logic                       first,
  input  logic [rbb_pkg::CNT_W-1:0]  amount,
  input  logic [rbb_pkg::OFF_W-1:0]  offset,
  input  logic                       cfg_write,
  input  logic [rbb_pkg::CNT_W-1:0]  cfg_data,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_addr,
  output logic [rbb_pkg::DATA_W-1:0] mem_wdata,
  input  logic [rbb_pkg::DATA_W-1:0] mem_rdata,
  output logic                       done,
  output logic [rbb_pkg::DATA_W-1:0] byte_out,
  output logic [rbb_pkg::STAT_W-1:0] status,
  output logic [rbb_pkg::CNT_W-1:0]  removed,
  output logic [rbb_pkg::CNT_W-1:0]  fill
);

  localparam int unsigned CW = rbb_pkg::CNT_W;
  localparam int unsigned IW = ((AW > CW) ? AW : CW) + 1;

  rbb_pkg::state_t state, state_next;

  logic [CW-1:0] cap;
  logic [AW-1:0] widx, widx_next;
  logic [AW-1:0] ridx, ridx_next;
  logic [CW-1:0] held, held_next;
  logic          wacc, wacc_next;

  logic          accept;
  logic          need_read;
  logic [rbb_pkg::STAT_W-1:0] stat_c;
  logic [CW-1:0] rem_c;
  logic          put_ok;
  logic          room_ok;
  logic          adm;
  logic [AW-1:0] peek_pos;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [CW-1:0] b,
                                             input logic [CW-1:0] c);
    logic [IW-1:0] s;
    s = IW'(a) + IW'(b);
    if (s >= IW'(c)) begin
      s = s - IW'(c);
    end
    return s[AW-1:0];
  endfunction

  assign busy   = (state == rbb_pkg::S_READ);
  assign accept = start && !busy;

  assign room_ok  = ({1'b0, held} + {1'b0, amount}) <= {1'b0, cap};
  assign adm      = first ? room_ok : wacc;
  assign put_ok   = adm && (held < cap);
  assign peek_pos = wrap_add(ridx, CW'(offset), cap);

  always_comb begin
    widx_next  = widx;
    ridx_next  = ridx;
    held_next  = held;
    wacc_next  = wacc;
    stat_c     = rbb_pkg::ST_DONE;
    rem_c      = '0;
    need_read  = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = ridx;
    mem_wdata  = data;
    state_next = state;
    case (state)
      rbb_pkg::S_IDLE: begin
        if (accept) begin
          case (rbb_pkg::action_t'(action))
            rbb_pkg::ACT_PUT: begin
              mem_addr = widx;
              if (first && amount == '0) begin
                wacc_next = 1'b0;
              end else if (put_ok) begin
                mem_we    = 1'b1;
                widx_next = wrap_add(widx, CW'(1), cap);
                held_next = held + CW'(1);
                wacc_next = 1'b1;
              end else begin
                wacc_next = 1'b0;
                stat_c    = rbb_pkg::ST_NO_ROOM;
              end
            end
            rbb_pkg::ACT_GET: begin
              if (held == '0) begin
                stat_c = rbb_pkg::ST_EMPTY;
              end else begin
                need_read = 1'b1;
                ridx_next = wrap_add(ridx, CW'(1), cap);
                held_next = held - CW'(1);
              end
            end
            rbb_pkg::ACT_PEEK: begin
              mem_addr = peek_pos;
              if (CW'(offset) >= held) begin
                stat_c = rbb_pkg::ST_EMPTY;
              end else begin
                need_read = 1'b1;
              end
            end
            rbb_pkg::ACT_DISCARD: begin
              rem_c     = (amount < held) ? amount : held;
              ridx_next = wrap_add(ridx, rem_c, cap);
              held_next = held - rem_c;
            end
            default: begin
            end
          endcase
          if (need_read) begin
            state_next = rbb_pkg::S_READ;
          end
        end
      end
      rbb_pkg::S_READ: begin
        state_next = rbb_pkg::S_IDLE;
      end
      default: begin
        state_next = rbb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap  <= rbb_pkg::eff_cap(rbb_pkg::CAP_RESET, DEPTH);
      widx <= '0;
      ridx <= '0;
      held <= '0;
      wacc <= 1'b0;
    end else if (cfg_write) begin
      cap  <= rbb_pkg::eff_cap(cfg_data, DEPTH);
      widx <= '0;
      ridx <= '0;
      held <= '0;
      wacc <= 1'b0;
    end else begin
      widx <= widx_next;
      ridx <= ridx_next;
      held <= held_next;
      wacc <= wacc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && !need_read) || busy;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_out <= '0;
      status   <= stat_c;
      removed  <= rem_c;
      fill     <= held_next;
    end else if (busy) begin
      byte_out <= mem_rdata;
    end
  end

endmodule

// ----- rtl/ring_byte_buffer_with_peek.sv -----
// top level of the byte ring buffer with peek
//
// channel   signals                                   handshake
// command   start, action, data, first, amount,       beat taken when start && !busy
//           offset
// result    done, byte_out, status, removed, fill     beat valid while done is high
// config    cfg_write, cfg_data                       written when cfg_write is high
//
// put, discard and misses: result registered in the cycle after the beat, no busy
// get and peek that hit read the store: busy for one cycle, result taken from the store's read data
// the single store port allows one ram access per beat, read data registered
// synchronous reset empties the ring and sets capacity to 4096 (limited to DEPTH)
// a config write empties the ring; the result side cannot stall
module ring_byte_buffer_with_peek #(
  parameter int unsigned DEPTH = rbb_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [rbb_pkg::ACT_W-1:0]  action,
  input  logic [rbb_pkg::DATA_W-1:0] data,
  input  logic                       first,
  input  logic [rbb_pkg::CNT_W-1:0]  amount,
  input  logic [rbb_pkg::OFF_W-1:0]  offset,
  input  logic                       cfg_write,
  input  logic [rbb_pkg::CNT_W-1:0]  cfg_data,
  output logic                       done,
  output logic [rbb_pkg::DATA_W-1:0] byte_out,
  output logic [rbb_pkg::STAT_W-1:0] status,
  output logic [rbb_pkg::CNT_W-1:0]  removed,
  output logic [rbb_pkg::CNT_W-1:0]  fill
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                       mem_we;
  logic [AW-1:0]              mem_addr;
  logic [rbb_pkg::DATA_W-1:0] mem_wdata;
  logic [rbb_pkg::DATA_W-1:0] mem_rdata;

  rbb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .data      (data),
    .first     (first),
    .amount    (amount),
    .offset    (offset),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .done      (done),
    .byte_out  (byte_out),
    .status    (status),
    .removed   (removed),
    .fill      (fill)
  );

  rbb_store #(.DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

// ----- dv/testbench.sv -----
// testbench for the byte ring buffer with peek: directed table, then random commands checked
`timescale 1ns / 1ps

module testbench;

  localparam int LIMIT = 200000;
  localparam int unsigned DW = rbb_pkg::DATA_W;
  localparam int unsigned CW = rbb_pkg::CNT_W;
  localparam int unsigned OW = rbb_pkg::OFF_W;
  localparam int unsigned AT = rbb_pkg::ACT_W;
  localparam int unsigned SW = rbb_pkg::STAT_W;

  typedef struct packed {
    logic [DW-1:0]     byte_v;
    rbb_pkg::status_t  st;
    logic [CW-1:0]     rem;
    logic [CW-1:0]     fill_v;
  } beat_t;

  typedef struct packed {
    logic              is_cfg;
    logic              chk;
    rbb_pkg::action_t  act;
    logic [DW-1:0]     d;
    logic              f;
    logic [CW-1:0]     amt;
    logic [OW-1:0]     off;
    beat_t             want;
  } row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic [AT-1:0] action = '0;
  logic [DW-1:0] data = '0;
  logic          first = 1'b0;
  logic [CW-1:0] amount = '0;
  logic [OW-1:0] offset = '0;
  logic          cfg_write = 1'b0;
  logic [CW-1:0] cfg_data = '0;
  logic          busy;
  logic          done;
  logic [DW-1:0] byte_out;
  logic [SW-1:0] status;
  logic [CW-1:0] removed;
  logic [CW-1:0] fill;

  ring_byte_buffer_with_peek uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .data(data),
    .first(first), .amount(amount), .offset(offset), .cfg_write(cfg_write),
    .cfg_data(cfg_data), .done(done), .byte_out(byte_out), .status(status),
    .removed(removed), .fill(fill)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [DW-1:0] ring_mem [rbb_pkg::DEPTH_DEF];
  logic [OW-1:0] rd_ptr = '0;
  logic [OW-1:0] wr_ptr = '0;
  logic [CW-1:0] held_n = '0;
  logic          write_ok = 1'b0;
  logic [CW-1:0] cap_n = rbb_pkg::CAP_RESET;

  beat_t due_beats[$];
  row_t  plan[$];
  int    errors = 0;
  int    checked = 0;
  int    sent_items = 0;
  int    cfg_writes = 0;
  int    idle_pct = 0;
  int    cycles = 0;

  task automatic flag(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [OW-1:0] ring_wrap(input logic [OW-1:0] p,
                                              input logic [CW-1:0] n);
    logic [CW:0] s;
    s = {2'b00, p} + {1'b0, n};
    if (s >= {1'b0, cap_n}) s = s - {1'b0, cap_n};
    return s[OW-1:0];
  endfunction

  function automatic beat_t mk(input logic [DW-1:0] b, input rbb_pkg::status_t st,
                               input logic [CW-1:0] rem, input logic [CW-1:0] fl);
    beat_t r;
    r.byte_v = b;
    r.st = st;
    r.rem = rem;
    r.fill_v = fl;
    return r;
  endfunction

  function automatic beat_t ring_outcome(input rbb_pkg::action_t a, input logic [DW-1:0] d,
                                         input logic f, input logic [CW-1:0] amt,
                                         input logic [OW-1:0] off);
    beat_t r;
    r = mk('0, rbb_pkg::ST_DONE, '0, '0);
    case (a)
      rbb_pkg::ACT_PUT: begin
        if (f && amt == '0) begin
          write_ok = 1'b0;
        end else begin
          if (f) write_ok = ({1'b0, held_n} + {1'b0, amt}) <= {1'b0, cap_n};
          if (write_ok && held_n < cap_n) begin
            ring_mem[wr_ptr] = d;
            wr_ptr = ring_wrap(wr_ptr, CW'(1));
            held_n = held_n + CW'(1);
          end else begin
            write_ok = 1'b0;
            r.st = rbb_pkg::ST_NO_ROOM;
          end
        end
      end
      rbb_pkg::ACT_GET: begin
        if (held_n == '0) begin
          r.st = rbb_pkg::ST_EMPTY;
        end else begin
          r.byte_v = ring_mem[rd_ptr];
          rd_ptr = ring_wrap(rd_ptr, CW'(1));
          held_n = held_n - CW'(1);
        end
      end
      rbb_pkg::ACT_PEEK: begin
        if ({1'b0, off} >= held_n) r.st = rbb_pkg::ST_EMPTY;
        else r.byte_v = ring_mem[ring_wrap(rd_ptr, {1'b0, off})];
      end
      default: begin
        r.rem = (amt < held_n) ? amt : held_n;
        rd_ptr = ring_wrap(rd_ptr, r.rem);
        held_n = held_n - r.rem;
      end
    endcase
    r.fill_v = held_n;
    return r;
  endfunction

  task automatic send(input rbb_pkg::action_t a, input logic [DW-1:0] d, input logic f,
                      input logic [CW-1:0] amt, input logic [OW-1:0] off,
                      input logic chk, input beat_t want);
    beat_t e;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    action <= a;
    data <= d;
    first <= f;
    amount <= amt;
    offset <= off;
    do @(posedge clk); while (busy);
    e = ring_outcome(a, d, f, amt, off);
    due_beats.push_back(chk ? want : e);
    sent_items++;
  endtask

  task automatic set_capacity(input logic [CW-1:0] v);
    start <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (v == '0) cap_n = CW'(1);
    else if (32'(v) > rbb_pkg::DEPTH_DEF) cap_n = CW'(rbb_pkg::DEPTH_DEF);
    else cap_n = v;
    rd_ptr = '0;
    wr_ptr = '0;
    held_n = '0;
    write_ok = 1'b0;
    cfg_writes++;
  endtask

  function automatic void add(input logic is_cfg, input logic chk, input rbb_pkg::action_t a,
                              input logic [DW-1:0] d, input logic f,
                              input logic [CW-1:0] amt, input logic [OW-1:0] off,
                              input beat_t want);
    row_t r;
    r.is_cfg = is_cfg;
    r.chk = chk;
    r.act = a;
    r.d = d;
    r.f = f;
    r.amt = amt;
    r.off = off;
    r.want = want;
    plan.push_back(r);
  endfunction

  task automatic churn(input logic [CW-1:0] cap_cfg, input int pct, input int quota);
    int stop_at;
    int pick;
    int len;
    int extra;
    int top;
    logic [CW-1:0] amt;
    logic [OW-1:0] off;
    set_capacity(cap_cfg);
    idle_pct = pct;
    stop_at = sent_items + quota;
    while (sent_items < stop_at) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 40) begin
        top = (cap_n < CW'(12)) ? int'(cap_n) : 12;
        len = int'($urandom_range(1, top));
        amt = CW'(len);
        if ($urandom_range(0, 4) == 0) amt = CW'($urandom_range(len, int'(cap_n) + 4));
        extra = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 2)) : 0;
        for (int k = 0; k < len + extra; k++) begin
          send(rbb_pkg::ACT_PUT, DW'($urandom), k == 0, amt, OW'($urandom), 1'b0, '0);
        end
      end else if (pick < 58) begin
        send(rbb_pkg::ACT_GET, DW'($urandom), 1'($urandom), CW'($urandom), OW'($urandom),
             1'b0, '0);
      end else if (pick < 73) begin
        off = ($urandom_range(0, 4) == 0) ? OW'($urandom)
                                          : OW'($urandom_range(0, int'(held_n)));
        send(rbb_pkg::ACT_PEEK, DW'($urandom), 1'($urandom), CW'($urandom), off, 1'b0, '0);
      end else if (pick < 85) begin
        amt = ($urandom_range(0, 9) == 0) ? CW'($urandom)
                                          : CW'($urandom_range(0, int'(held_n) + 2));
        send(rbb_pkg::ACT_DISCARD, DW'($urandom), 1'($urandom), amt, OW'($urandom),
             1'b0, '0);
      end else if (pick < 90) begin
        send(rbb_pkg::ACT_PUT, DW'($urandom), 1'b1, '0, OW'($urandom), 1'b0, '0);
      end else begin
        send(rbb_pkg::action_t'($urandom_range(0, 3)), DW'($urandom), 1'($urandom),
             CW'($urandom), OW'($urandom), 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    beat_t w;
    if (!rst && done) begin
      if (due_beats.size() == 0) begin
        flag("result beat with nothing outstanding");
      end else begin
        w = due_beats.pop_front();
        checked++;
        if (byte_out !== w.byte_v)
          flag($sformatf("byte_out %0h, wanted %0h", byte_out, w.byte_v));
        if (status !== w.st)
          flag($sformatf("status %0d, wanted %0d", status, w.st));
        if (removed !== w.rem)
          flag($sformatf("removed %0d, wanted %0d", removed, w.rem));
        if (fill !== w.fill_v)
          flag($sformatf("fill %0d, wanted %0d", fill, w.fill_v));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, due_beats.size());
      $display("FAIL ring_byte_buffer_with_peek");
      $finish;
    end
  end

  initial begin
    // after reset: empty ring, capacity 4096, no write open
    add(1'b0, 1'b1, rbb_pkg::ACT_GET, '0, 1'b0, '0, '0,
        mk('0, rbb_pkg::ST_EMPTY, '0, '0));
    add(1'b0, 1'b1, rbb_pkg::ACT_PEEK, '0, 1'b0, '0, '1,
        mk('0, rbb_pkg::ST_EMPTY, '0, '0));
    add(1'b0, 1'b1, rbb_pkg::ACT_PUT, 8'hff, 1'b0, '0, '0,
        mk('0, rbb_pkg::ST_NO_ROOM, '0, '0));
    add(1'b0, 1'b1, rbb_pkg::ACT_DISCARD, '0, 1'b0, '1, '0,
        mk('0, rbb_pkg::ST_DONE, '0, '0));
    add(1'b0, 1'b1, rbb_pkg::ACT_PUT, '0, 1'b1, '0, '0,
        mk('0, rbb_pkg::ST_DONE, '0, '0));
    add(1'b0, 1'b1, rbb_pkg::ACT_PUT, 8'hff, 1'b1, '1, '0,
        mk('0, rbb_pkg::ST_NO_ROOM, '0, '0));
    add(1'b0, 1'b0, rbb_pkg::ACT_PUT, 8'hff, 1'b1, 13'd3, '0, '0);
    add(1'b0, 1'b0, rbb_pkg::ACT_PUT, 8'h00, 1'b0, 13'd3, '0, '0);
    add(1'b0, 1'b0, rbb_pkg::ACT_PUT, 8'ha5, 1'b0, 13'd3, '0, '0);
    add(1'b0, 1'b1, rbb_pkg::ACT_PEEK, '0, 1'b0, '0, '1,
        mk('0, rbb_pkg::ST_EMPTY, '0, 13'd3));
    add(1'b0, 1'b0, rbb_pkg::ACT_PEEK, '0, 1'b0, '0, 12'd2, '0);
    add(1'b0, 1'b0, rbb_pkg::ACT_GET, '0, 1'b0, '0, '0, '0);
    add(1'b0, 1'b0, rbb_pkg::ACT_DISCARD, '0, 1'b0, 13'd1, '0, '0);
    add(1'b0, 1'b0, rbb_pkg::ACT_GET, '0, 1'b0, '0, '0, '0);
    // tiny ring: refusal, overlong write, wrap
    add(1'b1, 1'b0, rbb_pkg::ACT_PUT, '0, 1'b0, 13'd3, '0, '0);
    add(1'b0, 1'b1, rbb_pkg::ACT_PUT, 8'h5a, 1'b1, 13'd4, '0,
        mk('0, rbb_pkg::ST_NO_ROOM, '0, '0));
    add(1'b0, 1'b0, rbb_pkg::ACT_PUT, 8'h5a, 1'b1, 13'd3, '0, '0);
    add(1'b0, 1'b0, rbb_pkg::ACT_PUT, 8'h3c, 1'b0, 13'd3, '0, '0);
    add(1'b0, 1'b0, rbb_pkg::ACT_PUT, 8'hc3, 1'b0, 13'd3, '0, '0);
    add(1'b0, 1'b1, rbb_pkg::ACT_PUT, 8'h99, 1'b0, 13'd3, '0,
        mk('0, rbb_pkg::ST_NO_ROOM, '0, 13'd3));
    add(1'b0, 1'b0, rbb_pkg::ACT_GET, '0, 1'b0, '0, '0, '0);
    add(1'b0, 1'b0, rbb_pkg::ACT_PUT, 8'h81, 1'b1, 13'd1, '0, '0);
    add(1'b0, 1'b0, rbb_pkg::ACT_PEEK, '0, 1'b0, '0, 12'd2, '0);
    add(1'b0, 1'b0, rbb_pkg::ACT_DISCARD, '0, 1'b0, '1, '0, '0);
    // zero capacity acts as one
    add(1'b1, 1'b0, rbb_pkg::ACT_PUT, '0, 1'b0, '0, '0, '0);
    add(1'b0, 1'b0, rbb_pkg::ACT_PUT, 8'h7e, 1'b1, 13'd1, '0, '0);
    add(1'b0, 1'b1, rbb_pkg::ACT_PUT, 8'h11, 1'b1, 13'd1, '0,
        mk('0, rbb_pkg::ST_NO_ROOM, '0, 13'd1));
    add(1'b0, 1'b0, rbb_pkg::ACT_GET, '0, 1'b0, '0, '0, '0);
    // oversized capacity acts as full depth
    add(1'b1, 1'b0, rbb_pkg::ACT_PUT, '0, 1'b0, '1, '0, '0);
    add(1'b0, 1'b0, rbb_pkg::ACT_PUT, 8'h42, 1'b1, 13'd4096, '0, '0);
    add(1'b0, 1'b0, rbb_pkg::ACT_PEEK, '0, 1'b0, '0, '0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_capacity(plan[i].amt);
      else send(plan[i].act, plan[i].d, plan[i].f, plan[i].amt, plan[i].off,
                plan[i].chk, plan[i].want);
    end

    churn(13'd1, 0, 245);
    churn(13'd2, 68, 245);
    churn(13'd7, 32, 245);
    churn(13'd4096, 0, 245);
    churn(13'd16, 68, 245);
    churn(13'd0, 32, 245);
    churn(13'h1fff, 68, 245);
    churn(13'($urandom_range(3, 40)), 0, 245);

    start <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("%0d commands over %0d capacity settings, %0d result beats checked",
             sent_items, cfg_writes, checked);
    $display("%0d mismatches", errors);
    if (errors == 0) $display("PASS ring_byte_buffer_with_peek");
    else $display("FAIL ring_byte_buffer_with_peek");
    $finish;
  end

endmodule
